FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros used by the kernel matrix entry module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define RBFK_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rbfk assertion failed");

// next-cycle implication, disabled during reset
`define RBFK_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rbfk assertion failed");

`endif

FILE: rtl/core/rbfk_pkg.sv
// ----------------------------------------------------------------------------
// rbfk_pkg
// Field widths, codes and constants of the RBF kernel matrix entry block.
// ----------------------------------------------------------------------------
package rbfk_pkg;

   // payload field widths
   localparam int KIND_W    = 1;
   localparam int ROW_W     = 8;
   localparam int ELEM_W    = 6;
   localparam int FEAT_W    = 16;
   localparam int COL_W     = 8;
   localparam int LABEL_W   = 9;
   localparam int KERNEL_W  = 16;
   localparam int STATUS_W  = 1;

   // register widths
   localparam int GAMMA_W     = 24;
   localparam int DIMS_W      = 7;
   localparam int VECS_W      = 9;
   localparam int CSR_DATA_W  = 24;
   localparam int CSR_INDEX_W = 2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_GAMMA   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIMS    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_VECTORS = 2'd2;

   // register reset values
   localparam logic [GAMMA_W-1:0] GAMMA_RESET = 24'd65536;
   localparam logic [DIMS_W-1:0]  DIMS_RESET  = 7'd64;
   localparam logic [VECS_W-1:0]  VECS_RESET  = 9'd256;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_LOAD  = 1'b0;
   localparam logic [KIND_W-1:0] KIND_QUERY = 1'b1;

   // result status
   localparam logic [STATUS_W-1:0] STATUS_OK    = 1'b0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 1'b1;

   // exponent argument saturates at 16.0 in Q.16
   localparam int ARG_FRAC_TOP = 20;

   // exp(-2^e) in Q0.32 for e = -10 .. 3, selected by e + 10
   function automatic logic [31:0] exp_pow2(input logic [3:0] sel);
      logic [31:0] val;
      case (sel)
         4'd0:    val = 32'd4290775039;
         4'd1:    val = 32'd4286586875;
         4'd2:    val = 32'd4278222805;
         4'd3:    val = 32'd4261543595;
         4'd4:    val = 32'd4228380000;
         4'd5:    val = 32'd4162825044;
         4'd6:    val = 32'd4034748382;
         4'd7:    val = 32'd3790295336;
         4'd8:    val = 32'd3344923894;
         4'd9:    val = 32'd2605029347;
         4'd10:   val = 32'd1580030169;
         4'd11:   val = 32'd581260615;
         4'd12:   val = 32'd78665070;
         4'd13:   val = 32'd1440801;
         default: val = 32'd0;
      endcase
      return val;
   endfunction

endpackage

FILE: rtl/core/rbfk_req_if.sv
// ----------------------------------------------------------------------------
// rbfk_req_if
// Request channel: load and query beats with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rbfk_req_if;
   logic                                valid;
   logic                                ready;
   logic [rbfk_pkg::KIND_W-1:0]         kind;
   logic [rbfk_pkg::ROW_W-1:0]          row_index;
   logic [rbfk_pkg::ELEM_W-1:0]         element_index;
   logic signed [rbfk_pkg::FEAT_W-1:0]  feature_value;
   logic [rbfk_pkg::COL_W-1:0]          col_index;

   modport source (
      output valid, kind, row_index, element_index, feature_value, col_index,
      input  ready
   );

   modport sink (
      input  valid, kind, row_index, element_index, feature_value, col_index,
      output ready
   );
endinterface

FILE: rtl/core/rbfk_rsp_if.sv
// ----------------------------------------------------------------------------
// rbfk_rsp_if
// Response channel: kernel entry beats with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rbfk_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [rbfk_pkg::LABEL_W-1:0]      row_label;
   logic [rbfk_pkg::COL_W-1:0]        col_out;
   logic [rbfk_pkg::KERNEL_W-1:0]     kernel_value;
   logic [rbfk_pkg::STATUS_W-1:0]     status;

   modport source (
      output valid, row_label, col_out, kernel_value, status,
      input  ready
   );

   modport sink (
      input  valid, row_label, col_out, kernel_value, status,
      output ready
   );
endinterface

FILE: rtl/core/rbf_kernel_matrix_entry.sv
// ----------------------------------------------------------------------------
// rbf_kernel_matrix_entry
// Gaussian RBF kernel matrix entry unit over a store of training vectors.
// ----------------------------------------------------------------------------
// A load beat writes one Q4.12 feature into the vector store and gives no
// response. A query beat reads the row and column vectors through the two
// read ports of the store, one feature pair per cycle, and accumulates the
// exact squared distance; it then scales by gamma and evaluates exp(-arg) by
// multiplying one exp(-2^e) constant per set bit of the table index, one bit
// per cycle. A query passes through the walk, scale, argument, exponent and
// done states in that order, and its response is loaded into the output
// register as it leaves the done state; with no dims in use the walk is
// skipped. The next beat can be taken as soon as that response is valid. A
// flagged query goes from idle straight to the done state. One item is in work
// at a time; a finished response sits in an output register, so the next beat
// is taken while it waits, and a query that finishes while that register is
// still full holds until it drains. The store has no reset; reading a feature
// that was never loaded gives an undefined kernel value.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rbf_kernel_matrix_entry #(
   parameter int MAX_VECTORS    = 256,
   parameter int MAX_DIMS       = 64,
   parameter int EXP_TABLE_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   rbfk_req_if.sink                            req_bus,
   rbfk_rsp_if.source                          rsp_bus,
   input  logic                                csr_wr_en,
   input  logic [rbfk_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rbfk_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   localparam int DEPTH     = MAX_VECTORS * MAX_DIMS;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int DCNT_W    = $clog2(MAX_DIMS + 1);
   localparam int DCMP_W    = (DCNT_W > rbfk_pkg::DIMS_W) ? DCNT_W : rbfk_pkg::DIMS_W;
   localparam int VCNT_W    = $clog2(MAX_VECTORS + 1);
   localparam int VCMP_W    = (VCNT_W > rbfk_pkg::VECS_W) ? VCNT_W : rbfk_pkg::VECS_W;
   localparam int DIFF_W    = rbfk_pkg::FEAT_W + 1;
   localparam int SQ_W      = 2 * rbfk_pkg::FEAT_W + 1;
   localparam int DIST_W    = SQ_W + $clog2(MAX_DIMS);
   localparam int LO_W      = 24;
   localparam int HI_W      = DIST_W - LO_W;
   localparam int PHI_W     = rbfk_pkg::GAMMA_W + HI_W;
   localparam int PLO_W     = rbfk_pkg::GAMMA_W + LO_W;
   localparam int ARG_W     = PHI_W + 1;
   localparam int BIT_W     = $clog2(EXP_TABLE_BITS);
   localparam int EXA_W     = 33;
   localparam int EXP_W     = EXA_W + 32;
   localparam int SEL_BASE  = 14 - EXP_TABLE_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_SCALE,
      ST_ARG,
      ST_EXP,
      ST_DONE
   } state_type;

   state_type state_ff;

   // configuration
   logic [rbfk_pkg::GAMMA_W-1:0] gamma_ff;
   logic [rbfk_pkg::DIMS_W-1:0]  dims_ff;
   logic [rbfk_pkg::VECS_W-1:0]  vecs_ff;

   // query work registers
   logic [rbfk_pkg::LABEL_W-1:0]  label_ff;
   logic [rbfk_pkg::COL_W-1:0]    col_ff;
   logic [rbfk_pkg::STATUS_W-1:0] status_ff;
   logic [DCNT_W-1:0]             nd_ff;
   logic [DCNT_W-1:0]             issue_cnt_ff;
   logic [ADDR_W-1:0]             addr_a_ff;
   logic [ADDR_W-1:0]             addr_b_ff;
   logic                          rd_vld_ff;
   logic                          sq_vld_ff;
   logic [SQ_W-1:0]               sq_ff;
   logic [DIST_W-1:0]             dist_ff;
   logic [PHI_W-1:0]              prod_hi_ff;
   logic [PLO_W-1:0]              prod_lo_ff;
   logic                          sat_ff;
   logic [EXP_TABLE_BITS-1:0]     idx_ff;
   logic [BIT_W-1:0]              bit_cnt_ff;
   logic [EXA_W-1:0]              ex_acc_ff;

   // response register
   logic                          rsp_vld_ff;
   logic [rbfk_pkg::LABEL_W-1:0]  rsp_label_ff;
   logic [rbfk_pkg::COL_W-1:0]    rsp_col_ff;
   logic [rbfk_pkg::KERNEL_W-1:0] rsp_kernel_ff;
   logic [rbfk_pkg::STATUS_W-1:0] rsp_status_ff;

   // combinational
   logic                          req_fire;
   logic                          is_load;
   logic                          is_query;
   logic [DCMP_W-1:0]             dims_ext;
   logic [DCMP_W-1:0]             nd_sel;
   logic [VCMP_W-1:0]             vecs_ext;
   logic [VCMP_W-1:0]             nv_sel;
   logic                          q_flag;
   logic                          load_ok;
   logic [ADDR_W-1:0]             row_base;
   logic [ADDR_W-1:0]             col_base;
   logic                          ram_we;
   logic [ADDR_W-1:0]             ram_wr_addr;
   logic [rbfk_pkg::FEAT_W-1:0]   ram_a_data;
   logic [rbfk_pkg::FEAT_W-1:0]   ram_b_data;
   logic                          issue;
   logic signed [DIFF_W-1:0]      diff;
   logic signed [2*DIFF_W-1:0]    sq_full;
   logic [ARG_W-1:0]              arg_sum;
   logic [3:0]                    pow_sel;
   logic [EXP_W-1:0]              ex_prod;
   logic [EXA_W-1:0]              ex_in;
   logic [EXA_W-1:0]              kv_round;
   logic [rbfk_pkg::KERNEL_W-1:0] kval;
   logic                          rsp_free;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign is_load  = req_fire && (req_bus.kind == rbfk_pkg::KIND_LOAD);
   assign is_query = req_fire && (req_bus.kind == rbfk_pkg::KIND_QUERY);

   // clip the in-use counts to the store size
   assign dims_ext = DCMP_W'(dims_ff);
   assign nd_sel   = (dims_ext < DCMP_W'(MAX_DIMS)) ? dims_ext : DCMP_W'(MAX_DIMS);
   assign vecs_ext = VCMP_W'(vecs_ff);
   assign nv_sel   = (vecs_ext < VCMP_W'(MAX_VECTORS)) ? vecs_ext : VCMP_W'(MAX_VECTORS);

   assign q_flag = (VCMP_W'(req_bus.row_index) >= nv_sel) ||
                   (VCMP_W'(req_bus.col_index) >= nv_sel);

   assign load_ok = (VCMP_W'(req_bus.row_index) < VCMP_W'(MAX_VECTORS)) &&
                    (DCMP_W'(req_bus.element_index) < DCMP_W'(MAX_DIMS));

   assign row_base = ADDR_W'(ADDR_W'(req_bus.row_index) * ADDR_W'(MAX_DIMS));
   assign col_base = ADDR_W'(ADDR_W'(req_bus.col_index) * ADDR_W'(MAX_DIMS));

   assign ram_we      = is_load && load_ok;
   assign ram_wr_addr = row_base + ADDR_W'(req_bus.element_index);

   rbfk_ram #(
      .WIDTH (rbfk_pkg::FEAT_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (ram_wr_addr),
      .wr_data   (req_bus.feature_value),
      .rd_a_addr (addr_a_ff),
      .rd_a_data (ram_a_data),
      .rd_b_addr (addr_b_ff),
      .rd_b_data (ram_b_data)
   );

   // walk: issue one feature pair per cycle until all in-use dims are read
   assign issue   = (state_ff == ST_WALK) && (issue_cnt_ff < nd_ff);
   assign diff    = DIFF_W'($signed(ram_a_data)) - DIFF_W'($signed(ram_b_data));
   assign sq_full = diff * diff;

   // arg = floor(gamma * dist / 2^24) split into high and low partial products
   assign arg_sum = ARG_W'(prod_hi_ff) + ARG_W'(prod_lo_ff[PLO_W-1:LO_W]);

   // bit-serial exponent: multiply by exp(-2^e) for each set index bit
   assign pow_sel  = 4'(bit_cnt_ff) + 4'(SEL_BASE);
   assign ex_prod  = EXP_W'(ex_acc_ff) * EXP_W'(rbfk_pkg::exp_pow2(pow_sel));
   assign ex_in    = EXA_W'((ex_prod + EXP_W'(33'h0_8000_0000)) >> 32);
   assign kv_round = ex_acc_ff + EXA_W'(33'h0_0001_0000);
   assign kval     = sat_ff ? '0 : kv_round[EXA_W-1:17];

   assign rsp_free = !rsp_vld_ff || rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rsp_vld_ff <= 1'b0;
         gamma_ff   <= rbfk_pkg::GAMMA_RESET;
         dims_ff    <= rbfk_pkg::DIMS_RESET;
         vecs_ff    <= rbfk_pkg::VECS_RESET;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               rbfk_pkg::CSR_GAMMA:   gamma_ff <= csr_wr_data;
               rbfk_pkg::CSR_DIMS:    dims_ff  <= csr_wr_data[rbfk_pkg::DIMS_W-1:0];
               rbfk_pkg::CSR_VECTORS: vecs_ff  <= csr_wr_data[rbfk_pkg::VECS_W-1:0];
               default: ;
            endcase
         end

         // load the response register as a query completes, else drain it
         if ((state_ff == ST_DONE) && rsp_free) begin
            rsp_vld_ff    <= 1'b1;
            rsp_label_ff  <= label_ff;
            rsp_col_ff    <= col_ff;
            rsp_kernel_ff <= kval;
            rsp_status_ff <= status_ff;
         end else if (rsp_bus.ready) begin
            rsp_vld_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (is_query) begin
                  label_ff     <= rbfk_pkg::LABEL_W'(req_bus.row_index) +
                                  rbfk_pkg::LABEL_W'(1);
                  col_ff       <= req_bus.col_index;
                  nd_ff        <= DCNT_W'(nd_sel);
                  issue_cnt_ff <= '0;
                  addr_a_ff    <= row_base;
                  addr_b_ff    <= col_base;
                  rd_vld_ff    <= 1'b0;
                  sq_vld_ff    <= 1'b0;
                  dist_ff      <= '0;
                  if (q_flag) begin
                     status_ff <= rbfk_pkg::STATUS_RANGE;
                     sat_ff    <= 1'b1;
                     state_ff  <= ST_DONE;
                  end else begin
                     status_ff <= rbfk_pkg::STATUS_OK;
                     state_ff  <= (nd_sel == '0) ? ST_SCALE : ST_WALK;
                  end
               end
            end
            ST_WALK: begin
               rd_vld_ff <= issue;
               if (issue) begin
                  addr_a_ff    <= addr_a_ff + ADDR_W'(1);
                  addr_b_ff    <= addr_b_ff + ADDR_W'(1);
                  issue_cnt_ff <= issue_cnt_ff + DCNT_W'(1);
               end
               sq_vld_ff <= rd_vld_ff;
               sq_ff     <= sq_full[SQ_W-1:0];
               if (sq_vld_ff) begin
                  dist_ff <= dist_ff + DIST_W'(sq_ff);
               end
               // advance once the read and square stages have drained
               if (!issue && !rd_vld_ff && !sq_vld_ff) begin
                  state_ff <= ST_SCALE;
               end
            end
            ST_SCALE: begin
               prod_hi_ff <= PHI_W'(gamma_ff) * PHI_W'(dist_ff[DIST_W-1:LO_W]);
               prod_lo_ff <= PLO_W'(gamma_ff) * PLO_W'(dist_ff[LO_W-1:0]);
               state_ff   <= ST_ARG;
            end
            ST_ARG: begin
               sat_ff     <= |arg_sum[ARG_W-1:rbfk_pkg::ARG_FRAC_TOP];
               idx_ff     <= arg_sum[rbfk_pkg::ARG_FRAC_TOP-1 -: EXP_TABLE_BITS];
               ex_acc_ff  <= EXA_W'(33'h1_0000_0000);
               bit_cnt_ff <= '0;
               state_ff   <= ST_EXP;
            end
            ST_EXP: begin
               if (idx_ff[0]) begin
                  ex_acc_ff <= ex_in;
               end
               idx_ff     <= idx_ff >> 1;
               bit_cnt_ff <= bit_cnt_ff + BIT_W'(1);
               if (bit_cnt_ff == BIT_W'(EXP_TABLE_BITS - 1)) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               // hold until the response register is free
               if (rsp_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_bus.ready        = (state_ff == ST_IDLE);
   assign rsp_bus.valid        = rsp_vld_ff;
   assign rsp_bus.row_label    = rsp_label_ff;
   assign rsp_bus.col_out      = rsp_col_ff;
   assign rsp_bus.kernel_value = rsp_kernel_ff;
   assign rsp_bus.status       = rsp_status_ff;

   `RBFK_ASSERT_IMP(a_walk_bound, clock, reset, state_ff == ST_WALK, issue_cnt_ff <= nd_ff)
   `RBFK_ASSERT_IMP(a_scale_drained, clock, reset, state_ff == ST_SCALE, !rd_vld_ff && !sq_vld_ff)
   `RBFK_ASSERT_IMP(a_exp_bound, clock, reset, state_ff == ST_EXP, bit_cnt_ff <= BIT_W'(EXP_TABLE_BITS - 1))
   `RBFK_ASSERT_IMP(a_flag_zero, clock, reset, rsp_vld_ff && rsp_status_ff == rbfk_pkg::STATUS_RANGE, rsp_kernel_ff == '0)
   `RBFK_ASSERT_IMP(a_kernel_max, clock, reset, rsp_vld_ff, rsp_kernel_ff <= 16'd32768)
   `RBFK_ASSERT_NXT(a_query_busy, clock, reset, is_query, state_ff != ST_IDLE)

endmodule

FILE: rtl/core/rbfk_ram.sv
// ----------------------------------------------------------------------------
// rbfk_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module rbfk_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   output logic [WIDTH-1:0]         rd_a_data,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_a_addr];
      rd_b_ff <= mem_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the RBF kernel matrix entry unit. Load and query
// beats go in through the request channel in random bursts. Kernel entries
// are predicted from an independent integer model of the feature store and
// the exp table, and each response beat is checked field by field in order.
// ----------------------------------------------------------------------------
module testbench;

   localparam int VEC_SLOTS     = 256;
   localparam int DIM_SLOTS     = 64;
   localparam int LUT_BITS      = 10;
   localparam int ITEM_TARGET   = 1050;
   localparam int SETTLE_CYCLES = 120;
   localparam int LONG_HOLD     = 400;
   localparam int STALL_LIMIT   = 4000;

   typedef struct {
      logic [rbfk_pkg::KIND_W-1:0]        kind;
      logic [rbfk_pkg::ROW_W-1:0]         row_index;
      logic [rbfk_pkg::ELEM_W-1:0]        element_index;
      logic signed [rbfk_pkg::FEAT_W-1:0] feature_value;
      logic [rbfk_pkg::COL_W-1:0]         col_index;
   } req_beat_type;

   typedef struct {
      logic [rbfk_pkg::LABEL_W-1:0]  row_label;
      logic [rbfk_pkg::COL_W-1:0]    col_out;
      logic [rbfk_pkg::KERNEL_W-1:0] kernel_value;
      logic [rbfk_pkg::STATUS_W-1:0] status;
   } kernel_entry_type;

   class kernel_scoreboard_type;
      logic signed [rbfk_pkg::FEAT_W-1:0] features [VEC_SLOTS*DIM_SLOTS];
      logic [rbfk_pkg::KERNEL_W-1:0]      exp_lut [1 << LUT_BITS];
      logic [rbfk_pkg::GAMMA_W-1:0]       gamma;
      int                                 dims;
      int                                 vectors;
      kernel_entry_type                   expected_entries [$];
      int                                 errors;

      function new();
         logic [31:0] neg_pow2 [14] = '{
            32'd4290775039, 32'd4286586875, 32'd4278222805, 32'd4261543595,
            32'd4228380000, 32'd4162825044, 32'd4034748382, 32'd3790295336,
            32'd3344923894, 32'd2605029347, 32'd1580030169, 32'd581260615,
            32'd78665070,   32'd1440801};
         logic [95:0] acc;
         // entry n = exp(-n/64), one constant per set bit of n
         for (int n = 0; n < (1 << LUT_BITS); n++) begin
            acc = 96'd1 << 32;
            for (int b = 0; b < LUT_BITS; b++) begin
               if ((n >> b) & 1)
                  acc = (acc * neg_pow2[4 + b] + (96'd1 << 31)) >> 32;
            end
            exp_lut[n] = rbfk_pkg::KERNEL_W'((acc + (96'd1 << 16)) >> 17);
         end
         set_config(rbfk_pkg::GAMMA_RESET, rbfk_pkg::DIMS_RESET, rbfk_pkg::VECS_RESET);
         errors = 0;
      endfunction

      function void set_config(logic [rbfk_pkg::GAMMA_W-1:0] g,
                               logic [rbfk_pkg::DIMS_W-1:0] d,
                               logic [rbfk_pkg::VECS_W-1:0] v);
         gamma   = g;
         dims    = (d > DIM_SLOTS) ? DIM_SLOTS : d;
         vectors = (v > VEC_SLOTS) ? VEC_SLOTS : v;
      endfunction

      function logic [rbfk_pkg::KERNEL_W-1:0] predict_kernel(int r, int c);
         longint      xa, xb, norm_r, norm_c, dot, sq_dist;
         logic [63:0] udist, arg;
         norm_r = 0;
         norm_c = 0;
         dot    = 0;
         for (int k = 0; k < dims; k++) begin
            xa = features[r*DIM_SLOTS + k];
            xb = features[c*DIM_SLOTS + k];
            norm_r += xa * xa;
            norm_c += xb * xb;
            dot    += xa * xb;
         end
         sq_dist = norm_r + norm_c - 2 * dot;
         if (sq_dist < 0) sq_dist = 0;
         udist = sq_dist;
         arg = 64'(gamma) * (udist >> 24) + ((64'(gamma) * 64'(udist[23:0])) >> 24);
         if (arg >= (64'd1 << rbfk_pkg::ARG_FRAC_TOP)) return '0;
         return exp_lut[LUT_BITS'(arg >> (rbfk_pkg::ARG_FRAC_TOP - LUT_BITS))];
      endfunction

      function void note_request(req_beat_type b);
         kernel_entry_type e;
         if (b.kind == rbfk_pkg::KIND_LOAD) begin
            features[{b.row_index, b.element_index}] = b.feature_value;
            return;
         end
         e.row_label = rbfk_pkg::LABEL_W'(b.row_index) + 1'b1;
         e.col_out   = b.col_index;
         if (b.row_index >= vectors || b.col_index >= vectors) begin
            e.status       = rbfk_pkg::STATUS_RANGE;
            e.kernel_value = '0;
         end else begin
            e.status       = rbfk_pkg::STATUS_OK;
            e.kernel_value = predict_kernel(b.row_index, b.col_index);
         end
         expected_entries.push_back(e);
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_response(kernel_entry_type got);
         kernel_entry_type want;
         if (expected_entries.size() == 0) begin
            $display("%0t: unexpected beat, expected none actual label %0d col %0d",
                     $time, got.row_label, got.col_out);
            errors++;
            return;
         end
         want = expected_entries.pop_front();
         compare_field("row_label", want.row_label, got.row_label);
         compare_field("col_out", want.col_out, got.col_out);
         compare_field("kernel_value", want.kernel_value, got.kernel_value);
         compare_field("status", want.status, got.status);
      endfunction

      function int pending();
         return expected_entries.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic                             csr_wr_en;
   logic [rbfk_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [rbfk_pkg::CSR_DATA_W-1:0]  csr_wr_data;

   rbfk_req_if req_bus ();
   rbfk_rsp_if rsp_bus ();

   rbf_kernel_matrix_entry u_top (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   kernel_scoreboard_type kernel_sb;
   bit  loaded [VEC_SLOTS][DIM_SLOTS];
   int  dims_now;
   int  vectors_now;
   int  items_sent = 0;
   int  burst_left = 0;
   int  idle_cycles = 0;
   bit  long_hold_armed = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // monitor both channels; a request beat is noted before a response is checked
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            kernel_sb.note_request('{kind: req_bus.kind, row_index: req_bus.row_index,
                                     element_index: req_bus.element_index,
                                     feature_value: req_bus.feature_value,
                                     col_index: req_bus.col_index});
         if (rsp_bus.valid && rsp_bus.ready)
            kernel_sb.check_response('{row_label: rsp_bus.row_label,
                                       col_out: rsp_bus.col_out,
                                       kernel_value: rsp_bus.kernel_value,
                                       status: rsp_bus.status});
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
   end

   initial begin
      wait (idle_cycles >= STALL_LIMIT);
      $display("FAILURE");
      $finish;
   end

   // response side: stall pattern of its own plus one long hold on request
   initial begin
      int mode, mode_left, hold_left;
      mode = 0;
      mode_left = 0;
      hold_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_armed) begin
            long_hold_armed = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 2);
               mode_left = $urandom_range(10, 300);
            end
            mode_left--;
            case (mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= 1'($urandom_range(0, 1));
               default: rsp_bus.ready <= (mode_left % 5 == 0);
            endcase
         end
      end
   end

   function automatic logic [rbfk_pkg::FEAT_W-1:0] pick_feature();
      int span;
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         1, 2, 3: return rbfk_pkg::FEAT_W'($urandom);
         default: begin
            // mostly near the origin so that kernel values spread over the table
            span = 1 << $urandom_range(3, 10);
            return rbfk_pkg::FEAT_W'($urandom_range(0, 2 * span) - span);
         end
      endcase
   endfunction

   function automatic int pick_vector();
      int pool;
      if (vectors_now == 0) return $urandom_range(0, VEC_SLOTS - 1);
      if (vectors_now < VEC_SLOTS && $urandom_range(0, 9) == 0)
         return $urandom_range(vectors_now, VEC_SLOTS - 1);
      if (dims_now <= 16 && $urandom_range(0, 9) == 0)
         return $urandom_range(0, vectors_now - 1);
      // keep wide vectors to a few slots so they are loaded once
      pool = (dims_now > 16) ? 4 : 12;
      if (pool > vectors_now) pool = vectors_now;
      return $urandom_range(0, pool - 1);
   endfunction

   task automatic push_beat(input req_beat_type b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid         <= 1'b1;
      req_bus.kind          <= b.kind;
      req_bus.row_index     <= b.row_index;
      req_bus.element_index <= b.element_index;
      req_bus.feature_value <= b.feature_value;
      req_bus.col_index     <= b.col_index;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   task automatic load_feature(input int v, input int e,
                               input logic [rbfk_pkg::FEAT_W-1:0] val);
      loaded[v][e] = 1'b1;
      push_beat('{kind: rbfk_pkg::KIND_LOAD, row_index: rbfk_pkg::ROW_W'(v),
                  element_index: rbfk_pkg::ELEM_W'(e), feature_value: val,
                  col_index: rbfk_pkg::COL_W'($urandom)});
   endtask

   task automatic fill_vector(input int v);
      for (int e = 0; e < dims_now; e++) begin
         if (!loaded[v][e]) load_feature(v, e, pick_feature());
      end
   endtask

   // make sure every element the query walks has been loaded first
   task automatic query_entry(input int r, input int c);
      if (r < vectors_now && c < vectors_now) begin
         fill_vector(r);
         fill_vector(c);
      end
      push_beat('{kind: rbfk_pkg::KIND_QUERY, row_index: rbfk_pkg::ROW_W'(r),
                  element_index: rbfk_pkg::ELEM_W'($urandom),
                  feature_value: rbfk_pkg::FEAT_W'($urandom),
                  col_index: rbfk_pkg::COL_W'(c)});
   endtask

   // step the clock before waiting so the last accepted beat is already noted
   task automatic settle();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (kernel_sb.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(input logic [rbfk_pkg::GAMMA_W-1:0] g,
                               input logic [rbfk_pkg::DIMS_W-1:0] d,
                               input logic [rbfk_pkg::VECS_W-1:0] v);
      settle();
      csr_wr_en   <= 1'b1;
      csr_index   <= rbfk_pkg::CSR_GAMMA;
      csr_wr_data <= rbfk_pkg::CSR_DATA_W'(g);
      @(posedge clock);
      csr_index   <= rbfk_pkg::CSR_DIMS;
      csr_wr_data <= rbfk_pkg::CSR_DATA_W'(d);
      @(posedge clock);
      csr_index   <= rbfk_pkg::CSR_VECTORS;
      csr_wr_data <= rbfk_pkg::CSR_DATA_W'(v);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      kernel_sb.set_config(g, d, v);
      dims_now    = (d > DIM_SLOTS) ? DIM_SLOTS : d;
      vectors_now = (v > VEC_SLOTS) ? VEC_SLOTS : v;
   endtask

   initial begin
      logic [rbfk_pkg::GAMMA_W-1:0] g;
      logic [rbfk_pkg::DIMS_W-1:0]  d;
      logic [rbfk_pkg::VECS_W-1:0]  v;
      int queries, phases;
      kernel_sb = new();
      dims_now = rbfk_pkg::DIMS_RESET;
      vectors_now = rbfk_pkg::VECS_RESET;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = rbfk_pkg::CSR_GAMMA;
      csr_wr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.kind = rbfk_pkg::KIND_LOAD;
      req_bus.row_index = '0;
      req_bus.element_index = '0;
      req_bus.feature_value = '0;
      req_bus.col_index = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // extremes of the features, saturation, identical vectors
      write_config(rbfk_pkg::GAMMA_RESET, 7'd1, 9'd256);
      load_feature(0, 0, 16'h7FFF);
      load_feature(255, 0, 16'h8000);
      load_feature(1, 0, 16'h0000);
      load_feature(255, 63, 16'h5A5A);
      load_feature(2, 0, 16'h0010);
      query_entry(0, 255);
      query_entry(255, 255);
      query_entry(0, 1);
      query_entry(1, 2);
      query_entry(255, 0);
      // zero gamma, column out of range, load past the vectors in use
      write_config('0, 7'd1, 9'd3);
      query_entry(0, 255);
      query_entry(0, 1);
      load_feature(200, 5, 16'h1234);
      // zero vectors in use flags everything
      write_config(24'hFFFFFF, 7'd0, 9'd0);
      query_entry(0, 0);
      // zero dims, oversized vector count
      write_config(24'hFFFFFF, 7'd0, 9'd511);
      query_entry(7, 9);
      query_entry(255, 254);

      phases = 0;
      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 5))
            0: g = '0;
            1: g = 24'hFFFFFF;
            2: g = rbfk_pkg::GAMMA_RESET;
            3: g = $urandom_range(1, 4096);
            4: g = $urandom_range(0, 1 << 20);
            default: g = $urandom_range(0, 24'hFFFFFF);
         endcase
         case ($urandom_range(0, 9))
            0: d = 7'd0;
            1: d = $urandom_range(65, 127);
            2: d = 7'd64;
            3: d = $urandom_range(9, 63);
            default: d = $urandom_range(1, 8);
         endcase
         case ($urandom_range(0, 9))
            0: v = 9'd0;
            1: v = $urandom_range(257, 511);
            2: v = 9'd256;
            3: v = 9'd1;
            default: v = $urandom_range(2, 12);
         endcase
         write_config(g, d, v);
         // back up the response side while requests keep coming
         if (phases == 1) long_hold_armed = 1'b1;
         queries = $urandom_range(10, 40);
         repeat (queries) begin
            if (items_sent >= ITEM_TARGET) break;
            if ($urandom_range(0, 4) == 0)
               load_feature($urandom_range(0, VEC_SLOTS - 1), $urandom_range(0, DIM_SLOTS - 1),
                            pick_feature());
            query_entry(pick_vector(), pick_vector());
         end
         phases++;
      end

      settle();
      if (kernel_sb.errors == 0 && kernel_sb.pending() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/rbfk_pkg.sv
rtl/core/rbfk_req_if.sv
rtl/core/rbfk_rsp_if.sv
rtl/core/rbfk_ram.sv
rtl/core/rbf_kernel_matrix_entry.sv
verif/testbench.sv
